// ----- hw/rtl/tch_pkg.sv -----
// Shared types, constants and CORDIC step functions for the tilt compensated heading core.
// Depends on nothing; used by tilt_compensated_heading_core.
package tch_pkg;

   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STAGES   = 16;
   localparam int TABLE_LEN       = 24;
   localparam int NUM_CSTG        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int WORK_BITS       = 16;
   localparam int RND_SHIFT       = WORK_BITS - ANGLE_FRAC_BITS;

   localparam int VEC_W = 50;
   localparam int ROT_W = 34;
   localparam int ANG_W = 20;
   localparam int MAG_W = 33;

   typedef logic signed [VEC_W-1:0] vec_data_type;
   typedef logic signed [ROT_W-1:0] rot_data_type;
   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic signed [15:0]      raw_type;

   localparam ang_type PI_W      = ANG_W'(205887);
   localparam ang_type HALF_PI_W = ANG_W'(102944);
   localparam ang_type RND_HALF  = ANG_W'(1 << (RND_SHIFT - 1));
   localparam rot_data_type INV_GAIN = ROT_W'(652032874);
   localparam logic [29:0]  INV_GAIN_U = 30'd652032874;

   typedef struct packed {
      vec_data_type x;
      vec_data_type y;
      ang_type      z;
      logic         zero;
   } vec_type;

   typedef struct packed {
      rot_data_type x;
      rot_data_type y;
      ang_type      a;
      logic         neg;
   } rot_type;

   typedef struct packed {
      raw_type      ax, ay, az, mx, my, mz;
      vec_type      va, vb;
      logic [MAG_W-1:0] mag_a, mag_b;
      ang_type      roll, pitch;
      rot_type      ra, rb;
      rot_data_type cr, sr, cp, sp;
      rot_data_type srsp, srcp;
      vec_data_type cpmx, spmz, crmy, t1, t2, h0, h1;
      logic signed [15:0] out_roll;
      logic signed [14:0] out_pitch;
      logic [15:0]  out_head;
   } pipe_type;

   function automatic ang_type atan_entry(input int i);
      ang_type r;
      case (i)
         0: r = ANG_W'(51472);
         1: r = ANG_W'(30386);
         2: r = ANG_W'(16055);
         3: r = ANG_W'(8150);
         4: r = ANG_W'(4091);
         5: r = ANG_W'(2047);
         6: r = ANG_W'(1024);
         7: r = ANG_W'(512);
         8: r = ANG_W'(256);
         9: r = ANG_W'(128);
         10: r = ANG_W'(64);
         11: r = ANG_W'(32);
         12: r = ANG_W'(16);
         13: r = ANG_W'(8);
         14: r = ANG_W'(4);
         15: r = ANG_W'(2);
         16: r = ANG_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic vec_data_type acc_ext(input raw_type v);
      return {{(VEC_W-32){v[15]}}, v, 16'b0};
   endfunction

   function automatic ang_type clamp(input ang_type v, input ang_type lim);
      ang_type r;
      if (v > lim) r = lim;
      else if (v < -lim) r = -lim;
      else r = v;
      return r;
   endfunction

   function automatic vec_type vec_init(input vec_data_type y, input vec_data_type x);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         v.z = (y >= 0) ? PI_W : -PI_W;
         v.x = -x;
         v.y = -y;
      end else begin
         v.z = '0;
         v.x = x;
         v.y = y;
      end
      return v;
   endfunction

   function automatic vec_type vec_step(input vec_type v, input int i);
      vec_type r;
      vec_data_type dx, dy;
      dx = v.y >>> i;
      dy = v.x >>> i;
      r = v;
      if (v.y >= 0) begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + atan_entry(i);
      end else begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - atan_entry(i);
      end
      return r;
   endfunction

   function automatic ang_type vec_angle(input vec_type v);
      return v.zero ? '0 : clamp(v.z, PI_W);
   endfunction

   function automatic logic [MAG_W-1:0] vec_mag(input vec_type v);
      logic [MAG_W+29:0] prod;
      prod = v.x[MAG_W-1:0] * INV_GAIN_U;
      return prod[MAG_W+29:30];
   endfunction

   function automatic rot_type rot_init(input ang_type a);
      rot_type r;
      r.x = INV_GAIN;
      r.y = '0;
      if (a > HALF_PI_W) begin
         r.a = a - PI_W;
         r.neg = 1'b1;
      end else if (a < -HALF_PI_W) begin
         r.a = a + PI_W;
         r.neg = 1'b1;
      end else begin
         r.a = a;
         r.neg = 1'b0;
      end
      return r;
   endfunction

   function automatic rot_type rot_step(input rot_type v, input int i);
      rot_type r;
      rot_data_type dx, dy;
      dx = v.y >>> i;
      dy = v.x >>> i;
      r = v;
      if (v.a >= 0) begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.a = v.a - atan_entry(i);
      end else begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.a = v.a + atan_entry(i);
      end
      return r;
   endfunction

   function automatic ang_type rnd_out(input ang_type a);
      ang_type t;
      t = a + RND_HALF;
      return t >>> RND_SHIFT;
   endfunction

   function automatic rot_data_type q30_mul(input rot_data_type a, input rot_data_type b);
      logic signed [2*ROT_W-1:0] p;
      p = a * b;
      return p[ROT_W+29:30];
   endfunction

   function automatic pipe_type f_pre1(input pipe_type p);
      pipe_type r;
      r = p;
      r.va = vec_init(acc_ext(p.az), acc_ext(p.ax));
      r.vb = vec_init(acc_ext(p.az), acc_ext(p.ay));
      return r;
   endfunction

   function automatic pipe_type f_vstep(input pipe_type p, input int i);
      pipe_type r;
      r = p;
      r.va = vec_step(p.va, i);
      r.vb = vec_step(p.vb, i);
      return r;
   endfunction

   function automatic pipe_type f_mag(input pipe_type p);
      pipe_type r;
      r = p;
      r.mag_a = vec_mag(p.va);
      r.mag_b = vec_mag(p.vb);
      return r;
   endfunction

   function automatic pipe_type f_pre2(input pipe_type p);
      pipe_type r;
      vec_data_type ma, mb;
      r = p;
      ma = {{(VEC_W-MAG_W){1'b0}}, p.mag_a};
      mb = {{(VEC_W-MAG_W){1'b0}}, p.mag_b};
      r.va = vec_init(acc_ext(p.ay), p.az[15] ? -ma : ma);
      r.vb = vec_init(-acc_ext(p.ax), mb);
      return r;
   endfunction

   function automatic pipe_type f_post2(input pipe_type p);
      pipe_type r;
      r = p;
      r.roll  = vec_angle(p.va);
      r.pitch = clamp(vec_angle(p.vb), HALF_PI_W);
      r.ra = rot_init(r.roll);
      r.rb = rot_init(r.pitch);
      return r;
   endfunction

   function automatic pipe_type f_rstep(input pipe_type p, input int i);
      pipe_type r;
      r = p;
      r.ra = rot_step(p.ra, i);
      r.rb = rot_step(p.rb, i);
      return r;
   endfunction

   function automatic pipe_type f_neg(input pipe_type p);
      pipe_type r;
      r = p;
      r.cr = p.ra.neg ? -p.ra.x : p.ra.x;
      r.sr = p.ra.neg ? -p.ra.y : p.ra.y;
      r.cp = p.rb.neg ? -p.rb.x : p.rb.x;
      r.sp = p.rb.neg ? -p.rb.y : p.rb.y;
      return r;
   endfunction

   function automatic pipe_type f_mul1(input pipe_type p);
      pipe_type r;
      r = p;
      r.srsp = q30_mul(p.sr, p.sp);
      r.srcp = q30_mul(p.sr, p.cp);
      r.cpmx = p.cp * p.mx;
      r.spmz = p.sp * p.mz;
      r.crmy = p.cr * p.my;
      return r;
   endfunction

   function automatic pipe_type f_mul2(input pipe_type p);
      pipe_type r;
      r = p;
      r.t1 = p.srsp * p.mx;
      r.t2 = p.srcp * p.mz;
      r.h0 = p.cpmx - p.spmz;
      return r;
   endfunction

   function automatic pipe_type f_sum(input pipe_type p);
      pipe_type r;
      r = p;
      r.h1 = p.t1 + p.crmy + p.t2;
      return r;
   endfunction

   function automatic pipe_type f_pre3(input pipe_type p);
      pipe_type r;
      r = p;
      r.va = vec_init(p.h1, p.h0);
      return r;
   endfunction

   function automatic pipe_type f_out(input pipe_type p);
      pipe_type r;
      ang_type h, ro, pi;
      r = p;
      h  = rnd_out(vec_angle(p.va) + PI_W);
      ro = rnd_out(p.roll);
      pi = rnd_out(p.pitch);
      r.out_head  = h[15:0];
      r.out_roll  = ro[15:0];
      r.out_pitch = pi[14:0];
      return r;
   endfunction

endpackage

// ----- hw/rtl/tilt_compensated_heading_core.sv -----
// Tilt compensated heading: roll, pitch and heading from raw accelerometer and magnetometer.
// The pipeline has 4 * CORDIC_STAGES + 10 register stages (74 at 16 stages) and takes one
// request per cycle while the output is not stalled.
// Four unrolled CORDIC pipelines set the depth; the whole pipeline stalls only while the
// output register holds an untaken result. Reset is synchronous and clears the valid bits.
// Uses tch_pkg.
module tilt_compensated_heading_core
   import tch_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (16 bits each)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // roll_angle[15:0], pitch_angle[30:16], heading_angle[46:31], zero pad[47]
   output logic [47:0] rsp_tdata
);

   localparam int S_PRE1  = 0;
   localparam int S_CA0   = S_PRE1 + 1;
   localparam int S_MAG   = S_CA0 + NUM_CSTG;
   localparam int S_PRE2  = S_MAG + 1;
   localparam int S_CB0   = S_PRE2 + 1;
   localparam int S_POST2 = S_CB0 + NUM_CSTG;
   localparam int S_CR0   = S_POST2 + 1;
   localparam int S_NEG   = S_CR0 + NUM_CSTG;
   localparam int S_MUL1  = S_NEG + 1;
   localparam int S_MUL2  = S_MUL1 + 1;
   localparam int S_SUM   = S_MUL2 + 1;
   localparam int S_PRE3  = S_SUM + 1;
   localparam int S_CC0   = S_PRE3 + 1;
   localparam int S_OUT   = S_CC0 + NUM_CSTG;
   localparam int NSTG    = S_OUT + 1;

   pipe_type          in_item;
   pipe_type          stage_in [NSTG];
   pipe_type          stage_ff [NSTG];
   logic [NSTG-1:0]   valid_ff;
   logic [NSTG-1:0]   valid_in;
   logic              adv;

   assign adv        = !valid_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[NSTG-1];
   assign rsp_tdata  = {1'b0, stage_ff[NSTG-1].out_head, stage_ff[NSTG-1].out_pitch,
                        stage_ff[NSTG-1].out_roll};

   always_comb begin
      in_item    = '0;
      in_item.ax = req_tdata[15:0];
      in_item.ay = req_tdata[31:16];
      in_item.az = req_tdata[47:32];
      in_item.mx = req_tdata[63:48];
      in_item.my = req_tdata[79:64];
      in_item.mz = req_tdata[95:80];
   end

   assign valid_in = {valid_ff[NSTG-2:0], req_tvalid};

   for (genvar k = 0; k < NSTG; k++) begin : g_stage
      if (k == S_PRE1) begin : g_pre1
         assign stage_in[k] = f_pre1(in_item);
      end else if (k < S_MAG) begin : g_ca
         assign stage_in[k] = f_vstep(stage_ff[k-1], k - S_CA0);
      end else if (k == S_MAG) begin : g_mag
         assign stage_in[k] = f_mag(stage_ff[k-1]);
      end else if (k == S_PRE2) begin : g_pre2
         assign stage_in[k] = f_pre2(stage_ff[k-1]);
      end else if (k < S_POST2) begin : g_cb
         assign stage_in[k] = f_vstep(stage_ff[k-1], k - S_CB0);
      end else if (k == S_POST2) begin : g_post2
         assign stage_in[k] = f_post2(stage_ff[k-1]);
      end else if (k < S_NEG) begin : g_cr
         assign stage_in[k] = f_rstep(stage_ff[k-1], k - S_CR0);
      end else if (k == S_NEG) begin : g_neg
         assign stage_in[k] = f_neg(stage_ff[k-1]);
      end else if (k == S_MUL1) begin : g_mul1
         assign stage_in[k] = f_mul1(stage_ff[k-1]);
      end else if (k == S_MUL2) begin : g_mul2
         assign stage_in[k] = f_mul2(stage_ff[k-1]);
      end else if (k == S_SUM) begin : g_sum
         assign stage_in[k] = f_sum(stage_ff[k-1]);
      end else if (k == S_PRE3) begin : g_pre3
         assign stage_in[k] = f_pre3(stage_ff[k-1]);
      end else if (k < S_OUT) begin : g_cc
         assign stage_in[k] = f_vstep(stage_ff[k-1], k - S_CC0);
      end else begin : g_out
         assign stage_in[k] = f_out(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NSTG; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during stall");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[46:31] <= 16'd51472)
      else $error("heading out of range");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[30:16]) <= 15'sd12868 &&
                      $signed(rsp_tdata[30:16]) >= -15'sd12868))
      else $error("pitch out of range");
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd25736 &&
                      $signed(rsp_tdata[15:0]) >= -16'sd25736))
      else $error("roll out of range");
`endif

endmodule

// ----- test/tilt_compensated_heading_checker.sv -----
// Checker for the tilt compensated heading core: watches both streams, predicts
// roll, pitch and heading per request with its own CORDIC model, and counts mismatches.
// Depends on nothing but the stream ports it observes.
module tilt_compensated_heading_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          errors,
   output int          pending
);

   localparam int FRAC = 13;
   localparam int STAGES = 16;
   localparam longint PI_Q16 = 205887;
   localparam longint HALF_PI_Q16 = 102944;
   localparam longint GAIN_COMP = 652032874;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic [15:0]        heading;
   } angles_type;

   angles_type angle_queue[$];

   function automatic longint arctan_step(int i);
      longint tbl[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 17) ? tbl[i] : 0;
   endfunction

   function automatic longint limit(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
   endfunction

   function automatic longint atan2_q16(longint y, longint x, output longint mag);
      longint z, nx, ny;
      mag = 0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q16 : -PI_Q16;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
         end
         x = nx; y = ny;
      end
      mag = (x * GAIN_COMP) >>> 30;
      return limit(z, PI_Q16);
   endfunction

   function automatic void sincos_q30(longint a, output longint c, output longint s);
      longint x, y, nx, ny;
      bit flip;
      x = GAIN_COMP; y = 0; flip = 0;
      if (a > HALF_PI_Q16) begin a -= PI_Q16; flip = 1; end
      else if (a < -HALF_PI_Q16) begin a += PI_Q16; flip = 1; end
      for (int i = 0; i < STAGES; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); a -= arctan_step(i);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); a += arctan_step(i);
         end
         x = nx; y = ny;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint to_frac(longint a);
      return (a + (1 << (15 - FRAC))) >>> (16 - FRAC);
   endfunction

   function automatic angles_type heading_of(logic [95:0] d);
      angles_type r;
      longint ax, ay, az, mx, my, mz, mxz, myz, dummy, roll, pitch, head;
      longint cr, sr, cp, sp, h0, h1, t;
      ax = longint'($signed(d[15:0])) * 65536;
      ay = longint'($signed(d[31:16])) * 65536;
      az = longint'($signed(d[47:32])) * 65536;
      mx = $signed(d[63:48]);
      my = $signed(d[79:64]);
      mz = $signed(d[95:80]);
      t = atan2_q16(az, ax, mxz);
      roll = atan2_q16(ay, (az < 0) ? -mxz : mxz, dummy);
      t = atan2_q16(az, ay, myz);
      pitch = limit(atan2_q16(-ax, myz, dummy), HALF_PI_Q16);
      sincos_q30(roll, cr, sr);
      sincos_q30(pitch, cp, sp);
      h0 = cp * mx - sp * mz;
      h1 = ((sr * sp) >>> 30) * mx + cr * my + ((sr * cp) >>> 30) * mz;
      head = atan2_q16(h1, h0, dummy) + PI_Q16;
      t = to_frac(roll);  r.roll = t[15:0];
      t = to_frac(pitch); r.pitch = t[14:0];
      t = to_frac(head);  r.heading = t[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      angles_type want;
      if (reset) begin
         errors <= 0;
         pending <= 0;
         angle_queue.delete();
      end else begin
         if (req_tvalid && req_tready) angle_queue.push_back(heading_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (angle_queue.size() == 0) begin
               $display("%0t unexpected response %h", $time, rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = angle_queue.pop_front();
               if (rsp_tdata[15:0] !== want.roll || rsp_tdata[30:16] !== want.pitch
                   || rsp_tdata[46:31] !== want.heading || rsp_tdata[47] !== 1'b0) begin
                  $display("%0t mismatch expected roll %0d pitch %0d heading %0d, actual %h",
                           $time, want.roll, want.pitch, want.heading, rsp_tdata);
                  errors <= errors + 1;
               end
            end
         end
         pending <= angle_queue.size();
      end
   end

endmodule

// ----- test/tilt_compensated_heading_core_test.sv -----
// Top of the heading core testbench: clock, reset, request stimulus and response stalls.
// Depends on tilt_compensated_heading_core, tch_pkg and tilt_compensated_heading_checker.
module tilt_compensated_heading_core_test;

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [95:0] req_tdata;
   logic [47:0] rsp_tdata;
   int          errors, pending;
   bit          calm;
   int          stall_left;

   tilt_compensated_heading_core dut (.*);

   tilt_compensated_heading_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send(logic [95:0] d);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // ready drops at random, in bursts, unless reset or calm is set
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_tready <= 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 0;
         stall_left = $urandom_range(1, 10);
      end else begin
         rsp_tready <= 1;
      end
   end

   initial begin
      logic [95:0] d;
      int          waited;
      req_tvalid = 0;
      req_tdata  = '0;
      rsp_tready = 1;
      calm  = 0;
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: zero vector, extremes, negative az, opposite direction, pure axes
      send('0);
      send({6{16'h7fff}});
      send({6{16'h8000}});
      send({16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h4000});
      send({16'h0000, 16'h0000, 16'h0100, 16'h8000, 16'h0000, 16'h0000});
      send({16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff});
      send({16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'hc000});
      send({16'h1234, 16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000});
      send({16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 16'h0000});
      send({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000});
      send({16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001});
      send({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
      for (int n = 0; n < 500; n++) begin
         if (n == 200) begin
            req_tvalid <= 0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         if (n == 420) calm = 1;
         for (int f = 0; f < 6; f++) d[16*f +: 16] = pick_value();
         send(d);
      end
      req_tvalid <= 0;
      waited = 0;
      while (pending != 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (100) @(negedge clock);
      if (errors == 0 && pending == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
